/* src/ean8_barcode_raster_generator_defines.svh */
// ----------------------------------------------------------------------------
// EAN-8 raster generator assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef EAN8_BARCODE_RASTER_GENERATOR_DEFINES_SVH
`define EAN8_BARCODE_RASTER_GENERATOR_DEFINES_SVH

// same-cycle implication
`define EAN8_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define EAN8_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* src/ean8_pkg.sv */
// ----------------------------------------------------------------------------
// EAN-8 package
// Register indexes, pattern layout and the L/R digit code tables.
// ----------------------------------------------------------------------------
`default_nettype none

package ean8_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_DIGITS  = 2'd0,
        CFG_QUIET   = 2'd1,
        CFG_MWIDTH  = 2'd2,
        CFG_BHEIGHT = 2'd3
    } t_cfg_reg;

    // pattern layout in modules
    localparam int PATTERN_MODULES = 67;
    localparam logic [6:0] LEFT_START   = 7'd3;
    localparam logic [6:0] CENTRE_START = 7'd31;
    localparam logic [6:0] RIGHT_START  = 7'd36;
    localparam logic [6:0] END_START    = 7'd64;
    localparam logic [6:0] PATTERN_END  = 7'd67;

    typedef logic [6:0] t_code;

    // left-hand odd-parity codes, first module in bit 6
    localparam t_code LCODE [10] = '{
        7'b0001101, 7'b0011001, 7'b0010011, 7'b0111101, 7'b0100011,
        7'b0110001, 7'b0101111, 7'b0111011, 7'b0110111, 7'b0001011
    };

    // right-hand codes, first module in bit 6
    localparam t_code RCODE [10] = '{
        7'b1110010, 7'b1100110, 7'b1101100, 7'b1000010, 7'b1011100,
        7'b1001110, 7'b1010000, 7'b1000100, 7'b1001000, 7'b1110100
    };

endpackage

`default_nettype wire

/* src/ean8_barcode_raster_generator.sv */
// ----------------------------------------------------------------------------
// EAN-8 barcode raster generator
// Emits one pixel of an EAN-8 symbol image per request word, in raster order.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                     payload
//  --------  ---------  ----------------------------  ---------------------------
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata[0] restart
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata[0] pixel, tlast row
//                                                     end, tuser frame end
//  cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
//  One word per cycle while m_axis does not stall: a request word is turned into
//  its pixel in the cycle it is accepted and lands in the output register.
//  s_axis_tready stays high while the output register is empty or being taken.
//  A stall on m_axis holds the output word and pauses input acceptance.
//  Synchronous active-low reset clears the counters and output valid and loads
//  the register defaults; config writes are always ready.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ean8_barcode_raster_generator_defines.svh"

module ean8_barcode_raster_generator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request words
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
    // pixel words
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [0] pixel, [7:1] zero
    output logic             m_axis_tlast,   // row end
    output logic             m_axis_tuser,   // [0] frame end
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    // configuration registers
    logic [31:0] r_digits;
    logic [7:0]  r_quiet;
    logic [3:0]  r_mwidth;
    logic [9:0]  r_bheight;

    // position counters
    logic [10:0] r_col,       n_col;
    logic [10:0] r_row,       n_row;
    logic [6:0]  r_mod_idx,   n_mod_idx;
    logic [3:0]  r_mod_phase, n_mod_phase;

    // output register
    logic        r_out_valid;
    logic        r_out_pix, r_out_rend, r_out_fend;

    logic        accept;
    logic        restart;
    logic [10:0] cur_col, cur_row;
    logic [6:0]  cur_idx;
    logic [3:0]  cur_phase;
    logic [3:0]  mw_eff;
    logic [10:0] span;
    logic [11:0] quiet12, span_end, bar_end, width_m1, height_m1;
    logic        in_span, in_rows;
    logic        mod_bar;
    logic        pix, rend, fend;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign restart       = s_axis_tdata[0];

    // take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits  <= '0;
            r_quiet   <= '0;
            r_mwidth  <= 4'd1;
            r_bheight <= 10'd64;
        end else if (i_cfg_valid) begin
            unique case (ean8_pkg::t_cfg_reg'(i_cfg_index))
                ean8_pkg::CFG_DIGITS:  r_digits  <= i_cfg_data;
                ean8_pkg::CFG_QUIET:   r_quiet   <= i_cfg_data[7:0];
                ean8_pkg::CFG_MWIDTH:  r_mwidth  <= i_cfg_data[3:0];
                ean8_pkg::CFG_BHEIGHT: r_bheight <= i_cfg_data[9:0];
            endcase
        end
    end

    // image geometry from the live registers
    always_comb begin
        mw_eff    = (r_mwidth == 4'd0) ? 4'd1 : r_mwidth;
        span      = 11'(ean8_pkg::PATTERN_MODULES) * {7'd0, mw_eff};
        quiet12   = {4'd0, r_quiet};
        span_end  = {1'b0, span} + quiet12;
        bar_end   = {2'd0, r_bheight} + quiet12;
        width_m1  = {1'b0, span} + {3'd0, r_quiet, 1'b0} - 12'd1;
        height_m1 = {2'd0, r_bheight} + {3'd0, r_quiet, 1'b0} - 12'd1;
    end

    // restart clears the position before the pixel is formed
    always_comb begin
        cur_col   = restart ? '0 : r_col;
        cur_row   = restart ? '0 : r_row;
        cur_idx   = restart ? '0 : r_mod_idx;
        cur_phase = restart ? '0 : r_mod_phase;
    end

    ean8_module_rom u_rom (
        .i_mod_idx (cur_idx),
        .i_digits  (r_digits),
        .o_bar     (mod_bar)
    );

    // form the pixel and its row/frame marks
    always_comb begin
        in_span = ({1'b0, cur_col} >= quiet12) && ({1'b0, cur_col} < span_end);
        in_rows = ({1'b0, cur_row} >= quiet12) && ({1'b0, cur_row} < bar_end);
        pix     = in_span && in_rows && mod_bar;
        rend    = ({1'b0, cur_col} >= width_m1);
        fend    = rend && ({1'b0, cur_row} >= height_m1);
    end

    // advance the counters
    always_comb begin
        n_col       = cur_col;
        n_row       = cur_row;
        n_mod_idx   = cur_idx;
        n_mod_phase = cur_phase;
        if (rend) begin
            n_col       = '0;
            n_mod_idx   = '0;
            n_mod_phase = '0;
            n_row       = fend ? '0 : cur_row + 11'd1;
        end else begin
            n_col = cur_col + 11'd1;
            if (in_span) begin
                if ({1'b0, cur_phase} + 5'd1 >= {1'b0, mw_eff}) begin
                    n_mod_phase = '0;
                    n_mod_idx   = cur_idx + 7'd1;
                end else begin
                    n_mod_phase = cur_phase + 4'd1;
                end
            end
        end
    end

    // hold the counters until a word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_mod_idx   <= '0;
            r_mod_phase <= '0;
        end else if (accept) begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_mod_idx   <= n_mod_idx;
            r_mod_phase <= n_mod_phase;
        end
    end

    // output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_pix  <= pix;
            r_out_rend <= rend;
            r_out_fend <= fend;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_pix};
    assign m_axis_tlast  = r_out_rend;
    assign m_axis_tuser  = r_out_fend;

    // checks
    `EAN8_ASSERT_NOW(a_fend_is_rend, r_out_valid && r_out_fend, r_out_rend, "frame end off a row end")
    `EAN8_ASSERT_NEXT(a_row_wrap, accept && rend, (r_col == '0) && (r_mod_idx == '0) && (r_mod_phase == '0), "counters not cleared at row end")
    `EAN8_ASSERT_NEXT(a_word_out, accept, r_out_valid, "accepted word not presented")

endmodule

`default_nettype wire

/* src/ean8_module_rom.sv */
// ----------------------------------------------------------------------------
// EAN-8 module lookup
// Maps a module index and the eight BCD digits to one bar/space bit.
// ----------------------------------------------------------------------------
`default_nettype none

module ean8_module_rom (
    input  wire logic [6:0]  i_mod_idx,
    input  wire logic [31:0] i_digits,
    output logic             o_bar
);

    logic [6:0] offs;
    logic [4:0] r;
    logic [1:0] q;
    logic [2:0] pos;
    logic [2:0] k;
    logic [3:0] digit;
    logic       right_half;

    // split the digit offset into digit slot and position within it
    always_comb begin
        right_half = (i_mod_idx >= ean8_pkg::RIGHT_START);
        offs = right_half ? (i_mod_idx - ean8_pkg::RIGHT_START)
                          : (i_mod_idx - ean8_pkg::LEFT_START);
        r = offs[4:0];
        priority if (r < 5'd7) begin
            q   = 2'd0;
            pos = r[2:0];
        end else if (r < 5'd14) begin
            q   = 2'd1;
            pos = 3'(r - 5'd7);
        end else if (r < 5'd21) begin
            q   = 2'd2;
            pos = 3'(r - 5'd14);
        end else begin
            q   = 2'd3;
            pos = 3'(r - 5'd21);
        end
        k     = {right_half, q};
        // first digit sits in the top nibble
        digit = i_digits[{~k, 2'b00} +: 4];
    end

    // pick the bit by pattern region
    always_comb begin
        priority if (i_mod_idx < ean8_pkg::LEFT_START) begin
            o_bar = (i_mod_idx == 7'd0) || (i_mod_idx == 7'd2);
        end else if (i_mod_idx < ean8_pkg::CENTRE_START) begin
            o_bar = (digit > 4'd9) ? 1'b0 : ean8_pkg::LCODE[digit][3'd6 - pos];
        end else if (i_mod_idx < ean8_pkg::RIGHT_START) begin
            // centre guard 01010: bars on even module indexes
            o_bar = ~i_mod_idx[0];
        end else if (i_mod_idx < ean8_pkg::END_START) begin
            o_bar = (digit > 4'd9) ? 1'b0 : ean8_pkg::RCODE[digit][3'd6 - pos];
        end else if (i_mod_idx < ean8_pkg::PATTERN_END) begin
            o_bar = (i_mod_idx == ean8_pkg::END_START) ||
                    (i_mod_idx == ean8_pkg::END_START + 7'd2);
        end else begin
            o_bar = 1'b0;
        end
    end

endmodule

`default_nettype wire
